// ===== src/fast_atan2_rational_defines.svh =====
// Assertion macros for the arctangent pipeline checks.
`ifndef FAST_ATAN2_RATIONAL_DEFINES_SVH
`define FAST_ATAN2_RATIONAL_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk_i, off during reset.
`define FAT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fat assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define FAT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fat assertion failed");

`else

`define FAT_ASSERT_IMPL(lbl, ante, cons)
`define FAT_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== src/fat_pkg.sv =====
// Shared widths, constants and payload types of the arctangent pipeline.
package fat_pkg;

  localparam int IN_W     = 16;                      // vector component width
  localparam int DEN_W    = IN_W + 1;                // |x| + |y| fits here
  localparam int REM_W    = IN_W + 2;                // shifted partial remainder
  localparam int Q_W      = 16;                      // ratio magnitude, Q1.15 plus one
  localparam int ANG_W    = 16;                      // Q2.13 angle
  localparam int R2_W     = Q_W + 1;                 // (r*r)>>15, 0..32768 signed
  localparam int T_W      = Q_W + 1;                 // A*r2 - B, signed
  localparam int P_W      = Q_W + 1;                 // (t*r)>>15, signed
  localparam int SUM_W    = ANG_W + 2;
  localparam int STEPS_PER_STAGE = 2;
  localparam int DIV_STAGES      = Q_W / STEPS_PER_STAGE;
  localparam int POLY_STAGES     = 4;
  localparam int S_TDATA_W = ((2 * IN_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((ANG_W + 7) / 8) * 8;

  localparam logic signed [Q_W-1:0]   R_MIN      = 16'sh8000;  // -1.0
  localparam logic signed [Q_W-1:0]   R_MAX      = 16'sh7fff;
  localparam logic signed [Q_W-1:0]   COEF_A     = 16'sd6432;   // 0.1963
  localparam logic signed [T_W-1:0]   COEF_B     = 17'sd32168;  // 0.9817
  localparam logic signed [ANG_W-1:0] BASE_QTR   = 16'sd6434;   // pi/4
  localparam logic signed [ANG_W-1:0] BASE_3QTR  = 16'sd19302;  // 3pi/4
  localparam logic signed [ANG_W-1:0] ANGLE_MIN  = -16'sd25736;
  localparam logic signed [ANG_W-1:0] ANGLE_MAX  = 16'sd25736;

  typedef struct packed {
    logic neg;      // numerator negative
    logic zero;     // zero vector, ratio forced to -1
    logic base_hi;  // x < 0, base 3pi/4
    logic yneg;     // y < 0, negate the angle
  } side_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [Q_W-1:0]   quo;
    side_t            side;
  } div_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic             qbit;
  } div_step_t;

  // One restoring division step; the first quotient bit takes no shift.
  function automatic div_step_t div_step(logic [REM_W-1:0] rem, logic [DEN_W-1:0] den,
                                         logic shl);
    logic [REM_W-1:0] trial;
    logic [REM_W-1:0] dext;
    div_step_t        res;
    trial = shl ? {rem[REM_W-2:0], 1'b0} : rem;
    dext  = REM_W'(den);
    if (trial >= dext) begin
      res.rem  = trial - dext;
      res.qbit = 1'b1;
    end else begin
      res.rem  = trial;
      res.qbit = 1'b0;
    end
    return res;
  endfunction

endpackage

// ===== src/fat_prep.sv =====
// Input stage: folds the vector into a numerator and denominator for the ratio.
module fat_prep (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [fat_pkg::IN_W-1:0]  x_i,
  input  logic [fat_pkg::IN_W-1:0]  y_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output fat_pkg::div_t             out_o
);
  import fat_pkg::*;

  logic                    v_q;
  div_t                    d_q;
  div_t                    d_d;
  logic                    rdy;
  logic signed [IN_W+1:0]  xs;
  logic signed [IN_W+1:0]  ys;
  logic signed [IN_W+1:0]  ays;
  logic signed [IN_W+1:0]  num;
  logic signed [IN_W+1:0]  den;
  logic [IN_W+1:0]         nmag;

  always_comb begin
    xs  = (IN_W+2)'($signed(x_i));
    ys  = (IN_W+2)'($signed(y_i));
    ays = ys[IN_W+1] ? -ys : ys;
    if (xs[IN_W+1]) begin
      num = xs + ays;
      den = ays - xs;
    end else begin
      num = xs - ays;
      den = xs + ays;
    end
    nmag = num[IN_W+1] ? (IN_W+2)'(-num) : (IN_W+2)'(num);
    d_d.rem          = REM_W'(nmag);
    d_d.den          = den[DEN_W-1:0];
    d_d.quo          = '0;
    d_d.side.neg     = num[IN_W+1];
    d_d.side.zero    = (den == '0);
    d_d.side.base_hi = xs[IN_W+1];
    d_d.side.yneg    = ys[IN_W+1];
  end

  assign rdy = !v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (rdy) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy && in_valid_i) begin
      d_q <= d_d;
    end
  end

  assign in_ready_o  = rdy;
  assign out_valid_o = v_q;
  assign out_o       = d_q;

endmodule

// ===== src/fat_div.sv =====
// Pipelined restoring divider: two quotient bits per stage, ratio in Q1.15.
module fat_div (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  fat_pkg::div_t in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output fat_pkg::div_t out_o
);
  import fat_pkg::*;

  logic [DIV_STAGES-1:0] v_q;
  logic [DIV_STAGES-1:0] vin;
  logic [DIV_STAGES:0]   rdy;
  div_t                  d_q [DIV_STAGES];
  div_t                  d_d [DIV_STAGES];

  assign rdy[DIV_STAGES] = out_ready_i;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    div_t din;

    if (k == 0) begin : g_first
      assign vin[k] = in_valid_i;
      assign din    = in_i;
    end else begin : g_next
      assign vin[k] = v_q[k-1];
      assign din    = d_q[k-1];
    end

    always_comb begin
      div_t      cur;
      div_step_t st;
      cur = din;
      for (int j = 0; j < STEPS_PER_STAGE; j++) begin
        st      = div_step(cur.rem, cur.den, !((k == 0) && (j == 0)));
        cur.rem = st.rem;
        cur.quo = {cur.quo[Q_W-2:0], st.qbit};
      end
      d_d[k] = cur;
    end

    assign rdy[k] = !v_q[k] || rdy[k+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= vin[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && vin[k]) begin
        d_q[k] <= d_d[k];
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[DIV_STAGES-1];
  assign out_o       = d_q[DIV_STAGES-1];

endmodule

// ===== src/fat_poly.sv =====
// Polynomial back end: signed ratio, cubic correction, base offset and sign.
module fat_poly (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  fat_pkg::div_t             in_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [fat_pkg::ANG_W-1:0] angle_o
);
  import fat_pkg::*;

  logic [POLY_STAGES-1:0] v_q;
  logic [POLY_STAGES-1:0] vin;
  logic [POLY_STAGES:0]   rdy;

  // stage 1: r and r*r
  logic signed [Q_W-1:0]    r;
  logic signed [2*Q_W-1:0]  rr;
  logic signed [R2_W-1:0]   r2_d, r2_q;
  logic signed [Q_W-1:0]    r1_q;
  side_t                    s1_q;
  // stage 2: t = A*r2 - B
  logic signed [2*Q_W-1:0]  ar2;
  logic signed [T_W-1:0]    t_d, t_q;
  logic signed [Q_W-1:0]    r2r_q;
  side_t                    s2_q;
  // stage 3: p = t*r
  logic signed [T_W+Q_W-1:0] tr;
  logic signed [P_W-1:0]    p_d, p_q;
  side_t                    s3_q;
  // stage 4: angle
  logic signed [SUM_W-1:0]  base;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  ang;
  logic [ANG_W-1:0]         ang_d, ang_q;

  always_comb begin
    priority if (in_i.side.zero) begin
      r = R_MIN;
    end else if (in_i.side.neg) begin
      r = -$signed(in_i.quo);
    end else if (in_i.quo[Q_W-1]) begin
      r = R_MAX;  // ratio of exactly +1 saturates
    end else begin
      r = $signed(in_i.quo);
    end
    rr   = (2*Q_W)'(r) * (2*Q_W)'(r);
    r2_d = R2_W'(rr >>> 15);

    ar2 = (2*Q_W)'(COEF_A) * (2*Q_W)'(r2_q);
    t_d = T_W'(ar2 >>> 15) - COEF_B;

    tr  = (T_W+Q_W)'(t_q) * (T_W+Q_W)'(r2r_q);
    p_d = P_W'(tr >>> 15);

    base  = s3_q.base_hi ? SUM_W'(BASE_3QTR) : SUM_W'(BASE_QTR);
    sum   = base + SUM_W'(p_q >>> 2);
    ang   = s3_q.yneg ? -sum : sum;
    ang_d = ang[ANG_W-1:0];
  end

  assign vin = {v_q[POLY_STAGES-2:0], in_valid_i};
  assign rdy[POLY_STAGES] = out_ready_i;

  for (genvar k = 0; k < POLY_STAGES; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < POLY_STAGES; k++) begin
        if (rdy[k]) begin
          v_q[k] <= vin[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && vin[0]) begin
      r2_q <= r2_d;
      r1_q <= r;
      s1_q <= in_i.side;
    end
    if (rdy[1] && vin[1]) begin
      t_q   <= t_d;
      r2r_q <= r1_q;
      s2_q  <= s1_q;
    end
    if (rdy[2] && vin[2]) begin
      p_q  <= p_d;
      s3_q <= s2_q;
    end
    if (rdy[3] && vin[3]) begin
      ang_q <= ang_d;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[POLY_STAGES-1];
  assign angle_o     = ang_q;

endmodule

// ===== src/fast_atan2_rational.sv =====
// Pipeline: 1 fold, 8 divider and 4 polynomial stages from request to angle.
// Throughput: one request per cycle when not stalled; every stage has a valid bit and ready,
// so empty stages keep filling while a finished angle waits on m_axis_tready_i.
// The 16 quotient bits of the ratio divider, two per stage, set the depth.
// Reset (rst_ni low, asynchronous) clears all valid bits; data registers keep contents.
module fast_atan2_rational (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [fat_pkg::S_TDATA_W-1:0] s_axis_tdata_i,  // x_coord, y_coord
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [fat_pkg::M_TDATA_W-1:0] m_axis_tdata_o   // angle
);
  import fat_pkg::*;

  logic             prep_v, prep_r;
  div_t             prep_d;
  logic             div_v, div_r;
  div_t             div_d;
  logic [ANG_W-1:0] angle;

  fat_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .x_i         (s_axis_tdata_i[IN_W-1:0]),
    .y_i         (s_axis_tdata_i[2*IN_W-1:IN_W]),
    .out_valid_o (prep_v),
    .out_ready_i (prep_r),
    .out_o       (prep_d)
  );

  fat_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (prep_v),
    .in_ready_o  (prep_r),
    .in_i        (prep_d),
    .out_valid_o (div_v),
    .out_ready_i (div_r),
    .out_o       (div_d)
  );

  fat_poly u_poly (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (div_v),
    .in_ready_o  (div_r),
    .in_i        (div_d),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .angle_o     (angle)
  );

  assign m_axis_tdata_o = M_TDATA_W'(angle);

`include "fast_atan2_rational_defines.svh"

  `FAT_ASSERT_IMPL(a_zero_flag_den, prep_v, (prep_d.den == '0) == prep_d.side.zero)
  `FAT_ASSERT_IMPL(a_quo_bound, div_v && !div_d.side.zero, div_d.quo <= 16'h8000)
  `FAT_ASSERT_IMPL(a_angle_range, m_axis_tvalid_o, ($signed(angle) >= ANGLE_MIN) && ($signed(angle) <= ANGLE_MAX))

endmodule

// ===== test/atan2_angle_checker.sv =====
// Angle checker for the arctangent pipeline: predicts each angle and compares results in order.
module atan2_angle_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  input  logic                          s_axis_tready_i,
  input  logic [fat_pkg::S_TDATA_W-1:0] s_axis_tdata_i,  // x_coord, y_coord
  input  logic                          m_axis_tvalid_i,
  input  logic                          m_axis_tready_i,
  input  logic [fat_pkg::M_TDATA_W-1:0] m_axis_tdata_i,  // angle
  output int                            fail_count_o,
  output int                            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint RatioA    = 6432;   // 0.1963 in Q1.15
  localparam longint RatioB    = 32168;  // 0.9817 in Q1.15
  localparam longint QuarterPi = 6434;   // pi/4 in Q2.13
  localparam longint ThreeQtPi = 19302;  // 3pi/4 in Q2.13

  logic signed [15:0] angle_expected_q[$];
  int                 fails;
  int                 seen;

  function automatic logic [15:0] predict_angle(logic signed [15:0] x_coord,
                                                logic signed [15:0] y_coord);
    longint x, y, ay, num, den, base, r, r2, t, p, ang;
    x  = x_coord;
    y  = y_coord;
    ay = (y < 0) ? -y : y;
    if (x < 0) begin
      num  = x + ay;
      den  = ay - x;
      base = ThreeQtPi;
    end else begin
      num  = x - ay;
      den  = x + ay;
      base = QuarterPi;
    end
    // zero vector: skip the division and take the ratio as -1
    if (den == 0) begin
      r = -32768;
    end else begin
      r = (num * 32768) / den;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
    end
    r2  = (r * r) >>> 15;
    t   = ((RatioA * r2) >>> 15) - RatioB;
    p   = (t * r) >>> 15;
    ang = base + (p >>> 2);
    if (y < 0) ang = -ang;
    return ang[15:0];
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns: angle check: %s", $time, what);
    fails++;
  endtask

  initial begin
    fails = 0;
    seen  = 0;
  end

  always @(posedge clk_i) begin
    logic signed [15:0] want;
    logic signed [15:0] got;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        angle_expected_q.push_back(predict_angle(s_axis_tdata_i[15:0], s_axis_tdata_i[31:16]));
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = m_axis_tdata_i[15:0];
        seen++;
        if (angle_expected_q.size() == 0) begin
          report_mismatch($sformatf("angle %0d with no request pending", got));
        end else begin
          want = angle_expected_q.pop_front();
          if (got !== want) begin
            report_mismatch($sformatf("result %0d: angle %0d, expected %0d", seen, got, want));
          end
        end
      end
    end
  end

  assign fail_count_o = fails;
  assign pending_o    = angle_expected_q.size();

endmodule

// ===== test/testbench.sv =====
// Top of the arctangent testbench: clock, reset, stimulus, back-pressure and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomVectors = 400;
  localparam int HoldOffCycles = 90;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          s_axis_tvalid_i;
  logic                          s_axis_tready_o;
  logic [fat_pkg::S_TDATA_W-1:0] s_axis_tdata_i;  // x_coord, y_coord
  logic                          m_axis_tvalid_o;
  logic                          m_axis_tready_i;
  logic [fat_pkg::M_TDATA_W-1:0] m_axis_tdata_o;  // angle

  int fail_count;
  int pending;
  bit sink_holding;  // set while the sink holds off; the source then sends back to back
  bit source_steady;
  bit sink_steady;

  fast_atan2_rational i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o
  );

  atan2_angle_checker i_checker (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i,
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i,
    .m_axis_tdata_i  (m_axis_tdata_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  // Offer one vector after a random gap and hold it until it is accepted.
  task automatic send_vector(input logic signed [15:0] x, input logic signed [15:0] y);
    int gap;
    if ($urandom_range(0, 29) == 0) source_steady = !source_steady;
    gap = (source_steady || sink_holding) ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {y, x};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  function automatic logic signed [15:0] near(input int v);
    return 16'(v + $signed($urandom_range(0, 6)) - 3);
  endfunction

  initial begin
    logic signed [15:0] dx[] = '{0, 1, 32767, -1, -32768, 0, 0, 0, 0, 32767, -32768, 32767,
                                 -32768, 100, -100, 100, -100, 5, -5, -7, 1, -32768, -1};
    logic signed [15:0] dy[] = '{0, 0, 0, 0, 0, 1, 32767, -1, -32768, 32767, -32768, -32768,
                                 32767, 100, 100, -100, -100, 3, 3, -2, -32768, 1, -1};
    logic signed [15:0] x, y;
    source_steady   = 1'b0;
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // axes, corners, diagonals and the zero vector
    foreach (dx[i]) send_vector(dx[i], dy[i]);

    for (int n = 0; n < RandomVectors; n++) begin
      case ($urandom_range(0, 3))
        0: begin
          x = 16'($urandom);
          y = 16'($urandom);
        end
        1: begin
          x = 16'(near(0) * 2);
          y = 16'(near(0) * 2);
        end
        2: begin
          // close to an axis
          x = 16'($urandom);
          y = near(0);
          if ($urandom_range(0, 1)) {x, y} = {y, x};
        end
        default: begin
          // close to a diagonal
          x = 16'($urandom);
          y = $urandom_range(0, 1) ? near(x) : near(-x);
        end
      endcase
      send_vector(x, y);
    end
    s_axis_tvalid_i <= 1'b0;

    // let the checker record the last request before polling
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Sink: random stalls, calm stretches, and one long hold-off to fill the pipeline.
  initial begin
    int stall;
    int taken;
    sink_holding    = 1'b0;
    sink_steady     = 1'b0;
    taken           = 0;
    m_axis_tready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 29) == 0) sink_steady = !sink_steady;
      stall = sink_steady ? 0 : $urandom_range(0, 13);
      if (taken == 120) begin
        sink_holding = 1'b1;
        stall        = HoldOffCycles;
      end
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      sink_holding = 1'b0;
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      taken++;
    end
  end

endmodule
